/* sv/mfi_pkg.sv */
// Shared widths, stage record types and the modular doubling-and-add step.
package mfi_pkg;

   // Width of the modulus and of every residue.
   localparam int MOD_BITS = 31;
   // Width of the incoming value.
   localparam int VALUE_BITS = 32;
   // Number of cells in one interleaved modular multiplication.
   localparam int MUL_CELLS = MOD_BITS;
   // Number of exponent bits, one multiplication row each.
   localparam int EXP_BITS = MOD_BITS;
   // Reset value of the modulus register.
   localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

   // Record carried through the initial reduction chain.
   typedef struct packed {
      logic [VALUE_BITS-1:0] val;
      logic [VALUE_BITS-1:0] rem;
   } red_type;

   // Record carried through the exponentiation chain.
   typedef struct packed {
      logic [MOD_BITS-1:0] acc;
      logic [MOD_BITS-1:0] base;
      logic [MOD_BITS-1:0] pa;
      logic [MOD_BITS-1:0] pb;
   } stage_type;

   // One step of interleaved multiplication: (2p + (y ? x : 0)) mod m, for p, x < m.
   function automatic logic [MOD_BITS-1:0] mod_step(input logic [MOD_BITS-1:0] p,
                                                    input logic [MOD_BITS-1:0] x,
                                                    input logic                y,
                                                    input logic [MOD_BITS-1:0] m);
      logic [MOD_BITS:0] d;
      logic [MOD_BITS:0] s;
      d = {p, 1'b0};
      if (d >= {1'b0, m}) begin
         d = d - {1'b0, m};
      end
      s = {1'b0, d[MOD_BITS-1:0]} + (y ? {1'b0, x} : '0);
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[MOD_BITS-1:0];
   endfunction

endpackage

/* sv/mfi_rcell.sv */
// One cell of the input reduction chain: shifts in one bit of the value and reduces.
module mfi_rcell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [mfi_pkg::MOD_BITS-1:0]  modulus,
   input  logic                          vbit,
   input  logic                          in_valid,
   input  mfi_pkg::red_type              in_data,
   output logic                          out_valid,
   output mfi_pkg::red_type              out_data
);
   import mfi_pkg::*;

   logic    valid_ff;
   red_type data_ff;
   red_type data_in;
   logic [VALUE_BITS-1:0] sh;

   // Remainder stays below the modulus, so one subtraction suffices.
   always_comb begin
      sh = {in_data.rem[VALUE_BITS-2:0], vbit};
      data_in.val = in_data.val;
      if (sh >= VALUE_BITS'(modulus)) begin
         data_in.rem = sh - VALUE_BITS'(modulus);
      end else begin
         data_in.rem = sh;
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

/* sv/mfi_cell.sv */
// One cell of the exponentiation chain: one multiplier bit of the square and the product.
module mfi_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [mfi_pkg::MOD_BITS-1:0]  modulus,
   input  logic                          ybit,
   input  logic                          is_last,
   input  logic                          ebit,
   input  logic                          in_valid,
   input  mfi_pkg::stage_type            in_data,
   output logic                          out_valid,
   output mfi_pkg::stage_type            out_data
);
   import mfi_pkg::*;

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;
   logic [MOD_BITS-1:0] pa_new;
   logic [MOD_BITS-1:0] pb_new;

   // Both products scan the bits of the base; the final cell of a row applies the exponent bit.
   always_comb begin
      pa_new = mod_step(in_data.pa, in_data.acc, ybit, modulus);
      pb_new = mod_step(in_data.pb, in_data.base, ybit, modulus);
      if (is_last) begin
         data_in.acc  = ebit ? pa_new : in_data.acc;
         data_in.base = pb_new;
         data_in.pa   = '0;
         data_in.pb   = '0;
      end else begin
         data_in.acc  = in_data.acc;
         data_in.base = in_data.base;
         data_in.pa   = pa_new;
         data_in.pb   = pb_new;
      end
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

/* sv/modular_inverse_fermat.sv */
// Top level: modulus register, reduction chain, exponentiation chain and result register.
// Computes value^(modulus-2) mod modulus, the inverse for a prime modulus. One item is
// taken every cycle while the chain advances; each result passes through 32 reduction
// cells, 31 x 31 multiplication cells and one output register, in that order. The whole
// chain halts while a result waits and the output is not ready. The modulus may only be
// written while no item is in flight.
module modular_inverse_fermat (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mfi_pkg::MOD_BITS-1:0]  csr_modulus,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mfi_pkg::VALUE_BITS-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mfi_pkg::MOD_BITS-1:0]  rsp_inverse
);
   import mfi_pkg::*;

   localparam int NCELLS = EXP_BITS * MUL_CELLS;

   logic [MOD_BITS-1:0] modulus_ff;
   logic [MOD_BITS-1:0] expo;
   logic                adv;
   logic                rsp_valid_ff;
   logic [MOD_BITS-1:0] rsp_inverse_ff;

   red_type   red_d [VALUE_BITS+1];
   logic      red_v [VALUE_BITS+1];
   stage_type st_d  [NCELLS+1];
   logic      st_v  [NCELLS+1];

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
      end else if (csr_valid) begin
         modulus_ff <= csr_modulus;
      end
   end
   assign csr_ready = 1'b1;
   assign expo = modulus_ff - MOD_BITS'(2);

   // The chain moves whenever the result register is free or being emptied.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Reduction of the value by the modulus, most significant bit first.
   assign red_v[0]     = req_valid;
   assign red_d[0].val = req_value;
   assign red_d[0].rem = '0;
   for (genvar k = 0; k < VALUE_BITS; k++) begin : g_red
      mfi_rcell u_rcell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .modulus   (modulus_ff),
         .vbit      (red_d[k].val[VALUE_BITS-1-k]),
         .in_valid  (red_v[k]),
         .in_data   (red_d[k]),
         .out_valid (red_v[k+1]),
         .out_data  (red_d[k+1])
      );
   end

   // Right-to-left square-and-multiply, one row of cells per exponent bit.
   assign st_v[0]      = red_v[VALUE_BITS];
   assign st_d[0].acc  = MOD_BITS'(1);
   assign st_d[0].base = red_d[VALUE_BITS].rem[MOD_BITS-1:0];
   assign st_d[0].pa   = '0;
   assign st_d[0].pb   = '0;
   for (genvar j = 0; j < EXP_BITS; j++) begin : g_row
      for (genvar i = 0; i < MUL_CELLS; i++) begin : g_col
         mfi_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .adv       (adv),
            .modulus   (modulus_ff),
            .ybit      (st_d[j*MUL_CELLS+i].base[MOD_BITS-1-i]),
            .is_last   (i == MUL_CELLS-1),
            .ebit      (expo[j]),
            .in_valid  (st_v[j*MUL_CELLS+i]),
            .in_data   (st_d[j*MUL_CELLS+i]),
            .out_valid (st_v[j*MUL_CELLS+i+1]),
            .out_data  (st_d[j*MUL_CELLS+i+1])
         );
      end
   end

   // Result register; a modulus below two gives zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= st_v[NCELLS];
      end
      if (adv) begin
         rsp_inverse_ff <= (modulus_ff < MOD_BITS'(2)) ? '0 : st_d[NCELLS].acc;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_inverse = rsp_inverse_ff;
endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the Fermat modular inverse block.
`timescale 1ns / 1ps

module testbench;
   import mfi_pkg::*;

   // Kinds of row in the directed stimulus table.
   typedef enum logic {ROW_MODULUS, ROW_VALUE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [VALUE_BITS-1:0] data;
      bit                    known;
      logic [MOD_BITS-1:0]   result;
   } directed_row_type;

   localparam int HOLD_CYCLES = 2500;
   localparam int SETTLE_CYCLES = 4;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [MOD_BITS-1:0]   csr_modulus = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [MOD_BITS-1:0]   rsp_inverse;

   // Predictor copy of the modulus register and the expected inverses in order.
   logic [MOD_BITS-1:0] model_modulus = MODULUS_RESET;
   logic [MOD_BITS-1:0] pending_inverses[$];

   int  mismatches = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  moduli_used = 0;
   bit  hold_results = 1'b0;
   bit  no_idle = 1'b0;

   modular_inverse_fermat i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_modulus (csr_modulus),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_inverse (rsp_inverse)
   );

   always #10 clock = ~clock;

   // Expected inverse: value^(m-2) mod m by right-to-left square-and-multiply.
   function automatic logic [MOD_BITS-1:0] fermat_inverse(input logic [VALUE_BITS-1:0] v,
                                                          input logic [MOD_BITS-1:0] m);
      longint unsigned acc;
      longint unsigned base;
      longint unsigned expo;
      longint unsigned mm;
      mm = m;
      if (mm < 2) begin
         return '0;
      end
      acc = 1;
      base = v % mm;
      for (expo = mm - 2; expo != 0; expo = expo >> 1) begin
         if ((expo & 1) != 0) begin
            acc = (acc * base) % mm;
         end
         base = (base * base) % mm;
      end
      return MOD_BITS'(acc % mm);
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(10, 40);
      end
   endfunction

   // Offer one value and wait for its transfer; valid stays high for a back-to-back item.
   task automatic send_value(input logic [VALUE_BITS-1:0] v, input bit known,
                             input logic [MOD_BITS-1:0] typed_result);
      int  gap;
      bit  taken;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do begin
         @(negedge clock);
         taken = req_ready;
         if (taken) begin
            pending_inverses.push_back(known ? typed_result : fermat_inverse(v, model_modulus));
            items_sent++;
         end
         @(posedge clock);
      end while (!taken);
   endtask

   // Drain the block, then write a new modulus.
   task automatic write_modulus(input logic [MOD_BITS-1:0] m);
      bit taken;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_modulus <= m;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      model_modulus = m;
      moduli_used++;
   endtask

   // Random values, biased towards multiples of the modulus and the field extremes.
   task automatic send_random(input int count);
      logic [VALUE_BITS-1:0] v;
      longint unsigned       k;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: begin
               k = $urandom_range(0, 3);
               v = VALUE_BITS'(k * model_modulus);
            end
            3: v = VALUE_BITS'(model_modulus - 1);
            4: v = $urandom_range(0, 15);
            default: v = $urandom;
         endcase
         send_value(v, 1'b0, '0);
      end
   endtask

   // Result side: random back-pressure, with one long hold-off on request.
   always @(posedge clock) begin
      if (hold_results) begin
         rsp_ready <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_results = 1'b0;
         rsp_ready <= 1'b1;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < 90) ? 1'b1 : (pick_gap() == 0);
      end
   end

   // Compare each result transfer with the oldest expected inverse.
   always @(negedge clock) begin
      logic [MOD_BITS-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_inverses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: inverse %0d", rsp_inverse);
            end
         end else begin
            want = pending_inverses.pop_front();
            if (rsp_inverse !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: inverse expected %0d, got %0d", want, rsp_inverse);
               end
            end
         end
      end
   end

   // Main stimulus: directed table, then random phases over several moduli.
   initial begin
      directed_row_type directed [22] = '{
         '{ROW_VALUE,   32'd0,          1'b1, 31'd0},
         '{ROW_VALUE,   32'd1,          1'b1, 31'd1},
         '{ROW_VALUE,   32'd2,          1'b1, 31'd500000004},
         '{ROW_VALUE,   32'd1000000006, 1'b1, 31'd1000000006},
         '{ROW_VALUE,   32'd1000000007, 1'b1, 31'd0},
         '{ROW_VALUE,   32'hFFFFFFFF,   1'b0, 31'd0},
         '{ROW_VALUE,   32'h80000000,   1'b0, 31'd0},
         '{ROW_VALUE,   32'h55555555,   1'b0, 31'd0},
         '{ROW_MODULUS, 32'd2,          1'b0, 31'd0},
         '{ROW_VALUE,   32'd0,          1'b1, 31'd1},
         '{ROW_VALUE,   32'd1,          1'b1, 31'd1},
         '{ROW_VALUE,   32'hFFFFFFFE,   1'b1, 31'd1},
         '{ROW_MODULUS, 32'd3,          1'b0, 31'd0},
         '{ROW_VALUE,   32'd2,          1'b1, 31'd2},
         '{ROW_VALUE,   32'd3,          1'b1, 31'd0},
         '{ROW_MODULUS, 32'h7FFFFFFF,   1'b0, 31'd0},
         '{ROW_VALUE,   32'hFFFFFFFF,   1'b1, 31'd1},
         '{ROW_VALUE,   32'h7FFFFFFF,   1'b1, 31'd0},
         '{ROW_VALUE,   32'h7FFFFFFE,   1'b1, 31'h7FFFFFFE},
         '{ROW_VALUE,   32'h2AAAAAAA,   1'b0, 31'd0},
         '{ROW_MODULUS, 32'd4,          1'b0, 31'd0},
         '{ROW_VALUE,   32'd3,          1'b0, 31'd0}
      };
      logic [MOD_BITS-1:0] random_moduli [8] = '{31'd1000000007, 31'd65537, 31'd97,
                                                 31'h7FFFFFFF, 31'd2, 31'd1000000,
                                                 31'd13, 31'd2147483629};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: extremes, special moduli, zero residues.
      foreach (directed[i]) begin
         if (directed[i].kind == ROW_MODULUS) begin
            write_modulus(directed[i].data[MOD_BITS-1:0]);
         end else begin
            send_value(directed[i].data, directed[i].known, directed[i].result);
         end
      end

      // Random phases, one per modulus.
      foreach (random_moduli[p]) begin
         write_modulus(random_moduli[p]);
         no_idle = (p == 2);
         if (p == 1) begin
            // Long receiver hold-off while the sender keeps offering.
            no_idle = 1'b1;
            hold_results = 1'b1;
            send_random(20);
            // Let the first results reach the held output, so later items stall.
            req_valid <= 1'b0;
            repeat (HOLD_CYCLES / 2) @(posedge clock);
            send_random(20);
            no_idle = 1'b0;
            send_random(25);
         end else if (p == 3) begin
            send_random(30);
            // Sender waits until every expected inverse has come back.
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_inverses.size() != 0) @(posedge clock);
            send_random(35);
         end else begin
            send_random(65);
         end
      end
      no_idle = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_inverses.size() != 0) @(posedge clock);
      repeat (1100) @(posedge clock);

      $display("Sent %0d values under %0d written moduli; %0d inverses checked.",
               items_sent, moduli_used, results_seen);
      $display("Moduli covered 2, 3, 4 and 2^31-1 with long output hold-off and drain.");
      if (mismatches == 0 && pending_inverses.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5ms;
      $display("Run timed out with %0d inverses outstanding.", pending_inverses.size());
      $display("testbench: errors");
      $finish;
   end

endmodule
